### rtl/cpk_pkg.sv
// ----------------------------------------------------------------------------
// CAN signal packer package
// Shared constants, divider control types and frame helper functions.
// ----------------------------------------------------------------------------
package cpk_pkg;

  // Largest data length of a classic CAN frame, in bytes.
  localparam logic [3:0] MAX_FRAME_BYTES = 4'd8;

  // Number of quotient bits produced by the iterative divider.
  localparam int unsigned DIV_STEPS = 64;

  // Start request towards the divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  // Divider status: busy while iterating, done pulses once at the end.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Mask covering the first nb bytes of the frame.
  function automatic logic [63:0] bytes_mask(input logic [3:0] nb);
    logic [63:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < nb) begin
        m[8*k +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  // Mask covering the low len bits (len up to 64).
  function automatic logic [63:0] len_mask(input logic [6:0] len);
    logic [63:0] m;
    for (int k = 0; k < 64; k++) begin
      m[k] = (7'(k) < len);
    end
    return m;
  endfunction

  // Reverse the byte order of a frame word.
  function automatic logic [63:0] byte_swap(input logic [63:0] v);
    logic [63:0] r;
    for (int k = 0; k < 8; k++) begin
      r[8*k +: 8] = v[8*(7-k) +: 8];
    end
    return r;
  endfunction

endpackage

### rtl/cpk_if.sv
// ----------------------------------------------------------------------------
// CAN signal packer channels
// Valid/ready interfaces for signal input, frame output and configuration.
// ----------------------------------------------------------------------------

// One CAN signal description per transaction.
interface cpk_in_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] physical_value;
  logic signed [47:0] value_offset;
  logic signed [31:0] scale_factor;
  logic signed [47:0] min_limit;
  logic signed [47:0] max_limit;
  logic [5:0]         start_bit;
  logic [6:0]         bit_length;
  logic               little_endian;
  logic               last_signal;

  modport source (
    output valid, physical_value, value_offset, scale_factor, min_limit,
           max_limit, start_bit, bit_length, little_endian, last_signal,
    input  ready
  );
  modport sink (
    input  valid, physical_value, value_offset, scale_factor, min_limit,
           max_limit, start_bit, bit_length, little_endian, last_signal,
    output ready
  );
endinterface

// One packed frame per transaction.
interface cpk_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] frame_data;
  logic [3:0]  byte_count;
  logic        zero_factor_seen;

  modport source (
    output valid, frame_data, byte_count, zero_factor_seen,
    input  ready
  );
  modport sink (
    input  valid, frame_data, byte_count, zero_factor_seen,
    output ready
  );
endinterface

// Frame length register write.
interface cpk_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] frame_bytes;

  modport source (
    output valid, frame_bytes,
    input  ready
  );
  modport sink (
    input  valid, frame_bytes,
    output ready
  );
endinterface

### rtl/cpk_div.sv
// ----------------------------------------------------------------------------
// CAN signal packer divider
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module cpk_div import cpk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_ctrl_t   ctrl_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output div_stat_t   stat_o,
  output logic [63:0] quotient_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] dvd_q, dvd_d;
  logic [31:0] dvs_q, dvs_d;
  logic [31:0] rem_q, rem_d;
  logic [32:0] rem_sh;
  logic [33:0] trial;
  logic        fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign rem_sh = {rem_q, dvd_q[63]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign fits   = ~trial[33];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[62:0], fits};
      rem_d = fits ? trial[31:0] : rem_sh[31:0];
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = dvd_q;

  // The result pulse only follows an iteration that was running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

  // A finished division never leaves the unit still iterating.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 6'(DIV_STEPS - 1) && !ctrl_i.start) |=> (!busy_q && done_q))
    else $error("divider did not finish after the last step");

  // The step counter rests at zero whenever the unit is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (cnt_q == '0))
    else $error("divider step count not at rest while idle");

endmodule

### rtl/can_signal_frame_packer.sv
// ----------------------------------------------------------------------------
// CAN signal frame packer
// Scales, clamps and rounds one CAN signal per transaction and packs it into
// a 64-bit frame in Intel or Motorola order; the frame leaves on the last one.
// ----------------------------------------------------------------------------
// Sequence: a nonzero factor runs the divider (64 quotient bits), then the five
// steps clamp high, clamp low, round, sign and pack; a new signal is taken only
// once the block is idle again. A zero factor skips the divider and the clamp
// and round steps and goes straight to the sign and pack steps.
// A last signal waits at the pack step while the previous frame is still held.
// Reset clears the frame, the error flag and the output valid; frame length 8.
module can_signal_frame_packer import cpk_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  cpk_in_if.sink    in_i,
  cpk_cfg_if.sink   cfg_i,
  cpk_out_if.source out_o
);

  // Sequencer codes.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_CLHI  = 3'd2;
  localparam logic [2:0] ST_CLLO  = 3'd3;
  localparam logic [2:0] ST_ROUND = 3'd4;
  localparam logic [2:0] ST_SIGN  = 3'd5;
  localparam logic [2:0] ST_PACK  = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [3:0]         frame_bytes_q;
  logic [63:0]        acc_q, acc_d;
  logic               sticky_q, sticky_d;
  logic               out_valid_q, out_valid_d;
  logic [63:0]        out_data_q, out_data_d;
  logic [3:0]         out_count_q, out_count_d;
  logic               out_flag_q, out_flag_d;

  logic signed [47:0] lo_q, lo_d, hi_q, hi_d;
  logic [5:0]         start_q, start_d;
  logic [6:0]         len_q, len_d;
  logic               intel_q, intel_d;
  logic               last_q, last_d;
  logic               qneg_q, qneg_d;
  logic signed [65:0] q_q, q_d;
  logic [48:0]        rmag_q, rmag_d;
  logic [63:0]        raw_q, raw_d;

  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [63:0]        quot;

  logic               in_acc;
  logic signed [48:0] diff;
  logic [48:0]        diff_neg;
  logic [47:0]        dmag;
  logic               fzero;
  logic [31:0]        fmag;
  logic signed [65:0] lim_sel;
  logic               q_gt, q_lt;
  logic [65:0]        qabs;
  logic [63:0]        rext;
  logic [3:0]         nb;
  logic [5:0]         m0;
  logic signed [7:0]  mshift;
  logic [5:0]         mneg;
  logic [63:0]        lmask, ins_data, ins_mask, big_data, big_mask, frm_mask;
  logic               pack_go;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;

  // Operand preparation at acceptance: difference magnitude and factor magnitude.
  assign diff     = {in_i.physical_value[47], in_i.physical_value}
                  - {in_i.value_offset[47], in_i.value_offset};
  assign diff_neg = 49'(-diff);
  assign dmag     = diff[48] ? diff_neg[47:0] : diff[47:0];
  assign fzero    = (in_i.scale_factor == 32'sd0);
  assign fmag     = in_i.scale_factor[31] ? 32'(-in_i.scale_factor)
                                          : in_i.scale_factor;

  assign div_ctrl.start = in_acc && !fzero;

  cpk_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i ({dmag, 16'h0000}),
    .divisor_i  (fmag),
    .stat_o     (div_stat),
    .quotient_o (quot)
  );

  // Shared limit comparator: upper limit first, then the lower one.
  assign lim_sel = (state_q == ST_CLHI) ? 66'(hi_q) : 66'(lo_q);
  assign q_gt    = (q_q > lim_sel);
  assign q_lt    = (q_q < lim_sel);

  // Rounding and sign helpers.
  assign qabs = q_q[65] ? 66'(-q_q) : q_q;
  assign rext = {15'h0000, rmag_q};

  // Effective frame length.
  assign nb       = (frame_bytes_q > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : frame_bytes_q;
  assign frm_mask = bytes_mask(nb);

  // Bit placement. Motorola bits run consecutively in big-endian bit order,
  // so they are placed in a byte-swapped word and swapped back.
  assign lmask    = len_mask(len_q);
  assign m0       = {start_q[5:3], ~start_q[2:0]};
  assign mshift   = 8'sd64 - $signed({2'b00, m0}) - $signed({1'b0, len_q});
  assign mneg     = 6'(-mshift);
  assign big_data = mshift[7] ? (raw_q >> mneg) : (raw_q << mshift[5:0]);
  assign big_mask = mshift[7] ? (lmask >> mneg) : (lmask << mshift[5:0]);
  assign ins_data = intel_q ? (raw_q << start_q) : byte_swap(big_data);
  assign ins_mask = (intel_q ? (lmask << start_q) : byte_swap(big_mask)) & frm_mask;

  assign pack_go = !last_q || !out_valid_q || out_o.ready;

  // Sequencer and datapath next state.
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    sticky_d    = sticky_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    out_count_d = out_count_q;
    out_flag_d  = out_flag_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    start_d     = start_q;
    len_d       = len_q;
    intel_d     = intel_q;
    last_d      = last_q;
    qneg_d      = qneg_q;
    q_d         = q_q;
    rmag_d      = rmag_q;
    raw_d       = raw_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          lo_d    = in_i.min_limit;
          hi_d    = in_i.max_limit;
          start_d = in_i.start_bit;
          len_d   = (in_i.bit_length > 7'd64) ? 7'd64 : in_i.bit_length;
          intel_d = in_i.little_endian;
          last_d  = in_i.last_signal;
          qneg_d  = diff[48] ^ in_i.scale_factor[31];
          if (fzero) begin
            sticky_d = 1'b1;
            qneg_d   = 1'b0;
            rmag_d   = '0;
            state_d  = ST_SIGN;
          end else begin
            state_d  = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          q_d     = qneg_q ? 66'(-$signed({2'b00, quot})) : $signed({2'b00, quot});
          state_d = ST_CLHI;
        end
      end
      ST_CLHI: begin
        if (lo_q != hi_q && q_gt) begin
          q_d = lim_sel;
        end
        state_d = ST_CLLO;
      end
      ST_CLLO: begin
        if (lo_q != hi_q && q_lt) begin
          q_d = lim_sel;
        end
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        qneg_d  = q_q[65];
        rmag_d  = {1'b0, qabs[63:16]} + {48'h0, qabs[15]};
        state_d = ST_SIGN;
      end
      ST_SIGN: begin
        raw_d   = (qneg_q ? 64'(-rext) : rext) & len_mask(len_q);
        state_d = ST_PACK;
      end
      ST_PACK: begin
        if (pack_go) begin
          acc_d = (acc_q & ~ins_mask) | (ins_data & ins_mask);
          if (last_q) begin
            out_valid_d = 1'b1;
            out_data_d  = acc_d & frm_mask;
            out_count_d = nb;
            out_flag_d  = sticky_q;
            acc_d       = '0;
            sticky_d    = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      frame_bytes_q <= MAX_FRAME_BYTES;
      acc_q         <= '0;
      sticky_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      sticky_q    <= sticky_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        frame_bytes_q <= cfg_i.frame_bytes;
      end
    end
  end

  // Working registers of the current signal and the output payload.
  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    start_q     <= start_d;
    len_q       <= len_d;
    intel_q     <= intel_d;
    last_q      <= last_d;
    qneg_q      <= qneg_d;
    q_q         <= q_d;
    rmag_q      <= rmag_d;
    raw_q       <= raw_d;
    out_data_q  <= out_data_d;
    out_count_q <= out_count_d;
    out_flag_q  <= out_flag_d;
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.frame_data       = out_data_q;
  assign out_o.byte_count       = out_count_q;
  assign out_o.zero_factor_seen = out_flag_q;

  // A frame appears only after the last signal of a message has been packed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_PACK && $past(last_q)))
    else $error("frame presented without a packed last signal");

  // Emitting a frame leaves an empty accumulator and a clear error flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PACK && last_q && pack_go) |=> (acc_q == '0 && !sticky_q))
    else $error("frame state not cleared after emission");

  // The divider result is only consumed while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the division step");

  // A pending frame is never overwritten before it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_data_q)))
    else $error("pending frame lost or changed");

endmodule

### bench/tb_can_signal_frame_packer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CAN signal frame packer testbench
// Drives a directed stimulus plan and then random multi-signal frames through
// the signal channel and changes the frame length between phases. Every
// frame taken from the output is compared with its fixed expected frame or
// with a behavioural packer model that runs alongside, under three patterns of
// sender and receiver idling.
module tb_can_signal_frame_packer import cpk_pkg::*;;

  // Byte order codes carried in the little_endian field.
  localparam logic ORDER_INTEL    = 1'b1;
  localparam logic ORDER_MOTOROLA = 1'b0;

  // One in Q31.16 and Q15.16.
  localparam logic signed [47:0] ONE   = 48'sh1_0000;
  localparam logic signed [31:0] ONE_F = 32'sh1_0000;

  // Cycles the block may still be busy on a signal that emits no frame.
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic signed [47:0] physical_value;
    logic signed [47:0] value_offset;
    logic signed [31:0] scale_factor;
    logic signed [47:0] min_limit;
    logic signed [47:0] max_limit;
    logic [5:0]         start_bit;
    logic [6:0]         bit_length;
    logic               little_endian;
    logic               last_signal;
  } can_signal_t;

  typedef struct packed {
    logic [63:0] frame_data;
    logic [3:0]  byte_count;
    logic        zero_factor_seen;
  } frame_t;

  typedef enum logic {ROW_SIGNAL, ROW_FRAME_LEN} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [3:0]  frame_len;
    can_signal_t sig;
    bit          typed;
    frame_t      want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cpk_in_if  in_if ();
  cpk_cfg_if cfg_if ();
  cpk_out_if out_if ();

  can_signal_frame_packer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // Packer model state.
  logic [63:0] pending_frame;
  logic        pending_zero_factor;
  logic [3:0]  frame_len_reg;

  frame_t    frames_due [$];
  plan_row_t stim_plan [$];
  int        errors_seen;
  int        src_idle_pct;
  int        sink_idle_pct;

  // Clock generation.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Scaled, clamped and rounded raw value of a signal with a nonzero factor.
  function automatic logic [63:0] scaled_raw(input can_signal_t s);
    logic signed [32:0] fac;
    logic signed [48:0] diff;
    logic signed [65:0] quot, lo, hi;
    logic [63:0]        fmag, dmag, qmag, mag, rmag;
    logic               fneg, dneg, qneg;
    fac  = s.scale_factor;
    fneg = fac[32];
    fmag = fneg ? 64'(-fac) : 64'(fac);
    diff = s.physical_value - s.value_offset;
    dneg = diff[48];
    dmag = dneg ? 64'(-diff) : 64'(diff);
    qmag = (dmag << 16) / fmag;
    qneg = (dneg != fneg) && (qmag != 64'd0);
    quot = $signed({2'b00, qmag});
    if (qneg) quot = -quot;
    lo = s.min_limit;
    hi = s.max_limit;
    // The upper bound is applied first, so crossed limits end on the lower.
    if (s.min_limit != s.max_limit) begin
      if (quot > hi) quot = hi;
      if (quot < lo) quot = lo;
    end
    mag  = quot[65] ? 64'(-quot) : 64'(quot);
    rmag = (mag >> 16) + ((mag >> 15) & 64'd1);
    return quot[65] ? -rmag : rmag;
  endfunction

  // Write one frame bit, dropping bits outside the frame length.
  function automatic void place_bit(input int pos, input logic b, input int nb);
    if (pos >= 64 || pos / 8 >= nb) return;
    pending_frame[pos] = b;
  endfunction

  // Pack one accepted signal and work out the frame it emits, if any.
  task automatic pack_signal(input can_signal_t s, output bit emits, output frame_t f);
    logic [63:0] raw;
    int          nb, len, pos;
    nb  = (frame_len_reg > MAX_FRAME_BYTES) ? int'(MAX_FRAME_BYTES) : int'(frame_len_reg);
    len = (s.bit_length > 7'd64) ? 64 : int'(s.bit_length);
    if (s.scale_factor == 32'sd0) begin
      pending_zero_factor = 1'b1;
      raw = '0;
    end else begin
      raw = scaled_raw(s);
    end
    if (len < 64) raw &= (64'd1 << len) - 64'd1;
    if (s.little_endian == ORDER_INTEL) begin
      for (int i = 0; i < len; i++) place_bit(int'(s.start_bit) + i, raw[i], nb);
    end else begin
      // Motorola walks down each byte from the MSB, then on to the next byte.
      pos = int'(s.start_bit);
      for (int i = 0; i < len; i++) begin
        place_bit(pos, raw[len - 1 - i], nb);
        if (pos % 8 == 0) pos += 15;
        else pos -= 1;
        if (pos >= 64) break;
      end
    end
    emits = s.last_signal;
    f = '0;
    if (emits) begin
      f.frame_data       = pending_frame & ((nb >= 8) ? '1 : ((64'd1 << (8 * nb)) - 64'd1));
      f.byte_count       = 4'(nb);
      f.zero_factor_seen = pending_zero_factor;
      pending_frame       = '0;
      pending_zero_factor = 1'b0;
    end
  endtask

  function automatic can_signal_t mk_sig(
    input logic signed [47:0] val, input logic signed [47:0] off,
    input logic signed [31:0] fac, input logic signed [47:0] lo,
    input logic signed [47:0] hi, input int start, input int len,
    input logic order, input logic last
  );
    can_signal_t s;
    s.physical_value = val;
    s.value_offset   = off;
    s.scale_factor   = fac;
    s.min_limit      = lo;
    s.max_limit      = hi;
    s.start_bit      = 6'(start);
    s.bit_length     = 7'(len);
    s.little_endian  = order;
    s.last_signal    = last;
    return s;
  endfunction

  // A 48-bit value of random magnitude.
  function automatic logic signed [47:0] rand_q48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return $signed(r[47:0]) >>> $urandom_range(0, 47);
  endfunction

  function automatic can_signal_t random_signal(input logic last);
    can_signal_t        s;
    logic signed [47:0] a, b;
    int                 pick;
    s.physical_value = rand_q48();
    if ($urandom_range(2) == 0) s.value_offset = rand_q48();
    else s.value_offset = '0;
    // Factor: unity, zero, minus unity, or arbitrary ones of random magnitude.
    pick = $urandom_range(15);
    if (pick == 0) s.scale_factor = '0;
    else if (pick <= 5) s.scale_factor = ONE_F;
    else if (pick == 6) s.scale_factor = -ONE_F;
    else if (pick <= 11) s.scale_factor = $signed($urandom) >>> $urandom_range(8, 31);
    else s.scale_factor = $signed($urandom);
    // Limits: equal (no clamping), ordered, or arbitrary and possibly crossed.
    a = rand_q48();
    b = rand_q48();
    pick = $urandom_range(3);
    if (pick <= 1) begin
      s.min_limit = a;
      s.max_limit = a;
    end else if (pick == 2) begin
      s.min_limit = (a < b) ? a : b;
      s.max_limit = (a < b) ? b : a;
    end else begin
      s.min_limit = a;
      s.max_limit = b;
    end
    s.start_bit = 6'($urandom_range(63));
    pick = $urandom_range(19);
    if (pick == 0) s.bit_length = 7'd0;
    else if (pick <= 2) s.bit_length = 7'($urandom_range(65, 127));
    else if (pick <= 8) s.bit_length = 7'($urandom_range(1, 16));
    else s.bit_length = 7'($urandom_range(1, 64));
    s.little_endian = 1'($urandom_range(1));
    s.last_signal   = last;
    return s;
  endfunction

  task automatic plan_signal(input can_signal_t s);
    plan_row_t row;
    row.kind = ROW_SIGNAL;
    row.frame_len = '0;
    row.sig = s;
    row.typed = 1'b0;
    row.want = '0;
    stim_plan = {stim_plan, row};
  endtask

  task automatic plan_checked(input can_signal_t s, input frame_t f);
    plan_row_t row;
    row.kind = ROW_SIGNAL;
    row.frame_len = '0;
    row.sig = s;
    row.typed = 1'b1;
    row.want = f;
    stim_plan = {stim_plan, row};
  endtask

  task automatic plan_frame_len(input logic [3:0] v);
    plan_row_t row;
    row.kind = ROW_FRAME_LEN;
    row.frame_len = v;
    row.sig = '0;
    row.typed = 1'b0;
    row.want = '0;
    stim_plan = {stim_plan, row};
  endtask

  // Offer one signal, with random idle cycles first, and record what it emits.
  task automatic send_signal(input can_signal_t s, input bit typed, input frame_t want);
    bit     emits;
    frame_t f;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.physical_value <= s.physical_value;
    in_if.value_offset   <= s.value_offset;
    in_if.scale_factor   <= s.scale_factor;
    in_if.min_limit      <= s.min_limit;
    in_if.max_limit      <= s.max_limit;
    in_if.start_bit      <= s.start_bit;
    in_if.bit_length     <= s.bit_length;
    in_if.little_endian  <= s.little_endian;
    in_if.last_signal    <= s.last_signal;
    do @(posedge clk_i); while (!in_if.ready);
    pack_signal(s, emits, f);
    if (emits) frames_due = {frames_due, (typed ? want : f)};
  endtask

  // Let every frame drain and any frameless signal finish.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_frame_len(input logic [3:0] v);
    cfg_if.valid       <= 1'b1;
    cfg_if.frame_bytes <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid  <= 1'b0;
    frame_len_reg = v;
  endtask

  // Receiver readiness, stalling at the current rate.
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Compare each frame transaction with the oldest frame due.
  always @(posedge clk_i) begin : frame_check
    frame_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (frames_due.size() == 0) begin
        $error("frame with none due: frame_data %h", out_if.frame_data);
        errors_seen++;
      end else begin
        want = frames_due.pop_front();
        if (out_if.frame_data !== want.frame_data) begin
          $error("frame_data: expected %h, got %h", want.frame_data, out_if.frame_data);
          errors_seen++;
        end
        if (out_if.byte_count !== want.byte_count) begin
          $error("byte_count: expected %0d, got %0d", want.byte_count, out_if.byte_count);
          errors_seen++;
        end
        if (out_if.zero_factor_seen !== want.zero_factor_seen) begin
          $error("zero_factor_seen: expected %b, got %b",
                 want.zero_factor_seen, out_if.zero_factor_seen);
          errors_seen++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    #12_000_000;
    $display("tb_can_signal_frame_packer NOT OK");
    $finish;
  end

  initial begin
    int     sent, nsig;
    frame_t blank;
    blank               = '0;
    errors_seen         = 0;
    pending_frame       = '0;
    pending_zero_factor = 1'b0;
    frame_len_reg       = 4'd8;
    src_idle_pct        = 18;
    sink_idle_pct       = 49;
    rst_ni               <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.physical_value <= '0;
    in_if.value_offset   <= '0;
    in_if.scale_factor   <= '0;
    in_if.min_limit      <= '0;
    in_if.max_limit      <= '0;
    in_if.start_bit      <= '0;
    in_if.bit_length     <= '0;
    in_if.little_endian  <= 1'b0;
    in_if.last_signal    <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.frame_bytes   <= 4'd8;

    // Directed plan: unity scaling, zero factor, rounding, clamping, both byte
    // orders at the frame edges, odd lengths, overlap and frame length changes.
    plan_checked(mk_sig(ONE, 0, ONE_F, 0, 0, 0, 8, ORDER_INTEL, 1), '{64'h1, 4'd8, 1'b0});
    plan_checked(mk_sig(5 * ONE, 0, 0, 0, 0, 0, 8, ORDER_INTEL, 1), '{64'h0, 4'd8, 1'b1});
    plan_signal(mk_sig(ONE, 0, 0, 0, 0, 16, 8, ORDER_INTEL, 0));
    plan_signal(mk_sig(48'sh2_8000, 0, ONE_F, 0, 0, 8, 8, ORDER_INTEL, 0));
    plan_signal(mk_sig(-48'sh2_8000, 0, ONE_F, 0, 0, 24, 8, ORDER_INTEL, 1));
    plan_signal(mk_sig(1000 * ONE, 0, ONE_F, 0, 10 * ONE, 0, 16, ORDER_INTEL, 0));
    plan_signal(mk_sig(-50 * ONE, 0, ONE_F, -3 * ONE, 10 * ONE, 16, 8, ORDER_INTEL, 0));
    plan_signal(mk_sig(ONE, 0, ONE_F, 5 * ONE, 2 * ONE, 31, 8, ORDER_MOTOROLA, 0));
    plan_signal(mk_sig(3 * ONE, ONE, -32'sh2_0000, 0, 0, 39, 12, ORDER_MOTOROLA, 1));
    plan_checked(mk_sig(-ONE, 0, ONE_F, 0, 0, 0, 64, ORDER_INTEL, 1),
                 '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0});
    plan_signal(mk_sig(-ONE, 0, ONE_F, 0, 0, 7, 64, ORDER_MOTOROLA, 1));
    plan_signal(mk_sig(48'sh12, 0, 32'shFFFF_FFFF, 0, 0, 63, 16, ORDER_MOTOROLA, 0));
    plan_signal(mk_sig(48'hABCD * ONE, 0, ONE_F, 0, 0, 60, 16, ORDER_INTEL, 1));
    plan_signal(mk_sig(-ONE, 0, ONE_F, 0, 0, 0, 64, ORDER_INTEL, 0));
    plan_signal(mk_sig(7 * ONE, 0, ONE_F, 0, 0, 32, 0, ORDER_INTEL, 0));
    plan_signal(mk_sig(-3 * ONE, 0, ONE_F, 0, 0, 20, 127, ORDER_INTEL, 0));
    plan_signal(mk_sig(0, 0, ONE_F, 0, 0, 4, 8, ORDER_INTEL, 1));
    plan_frame_len(4'd0);
    plan_checked(mk_sig(-ONE, 0, ONE_F, 0, 0, 0, 64, ORDER_INTEL, 1), '{64'h0, 4'd0, 1'b0});
    plan_frame_len(4'd15);
    plan_checked(mk_sig(-ONE, 0, ONE_F, 0, 0, 0, 64, ORDER_INTEL, 1),
                 '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0});
    plan_frame_len(4'd8);
    plan_signal(mk_sig(48'sh7FFF_FFFF_FFFF, 48'sh8000_0000_0000, 32'sh1,
                       48'sh8000_0000_0000, 48'sh7FFF_FFFF_FFFF, 0, 64, ORDER_INTEL, 0));
    plan_signal(mk_sig(48'sh8000_0000_0000, 48'sh7FFF_FFFF_FFFF, 32'sh8000_0000,
                       0, 0, 55, 33, ORDER_MOTOROLA, 0));
    plan_signal(mk_sig(48'sh1234_5678_9ABC, -48'sh0F00_0000, 32'sh7FFF_FFFF,
                       0, 0, 40, 24, ORDER_MOTOROLA, 0));
    // The frame length drops while a frame is half built.
    plan_frame_len(4'd3);
    plan_signal(mk_sig(48'h55 * ONE, 0, ONE_F, 0, 0, 0, 8, ORDER_INTEL, 1));
    plan_frame_len(4'd8);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_plan[k]) begin
      if (stim_plan[k].kind == ROW_FRAME_LEN) begin
        wait_idle();
        write_frame_len(stim_plan[k].frame_len);
      end else begin
        send_signal(stim_plan[k].sig, stim_plan[k].typed, stim_plan[k].want);
      end
    end

    // Random frames of one to six signals, in three idling phases, with the
    // frame length changed between chunks.
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 18 : (ph == 1) ? 49 : 0;
      sink_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 18 : 0;
      for (int chunk = 0; chunk < 4; chunk++) begin
        wait_idle();
        case (chunk)
          0:       write_frame_len(4'd8);
          1:       write_frame_len(4'd0);
          2:       write_frame_len(4'd15);
          default: write_frame_len(4'($urandom_range(1, 14)));
        endcase
        sent = 0;
        while (sent < 165) begin
          nsig = $urandom_range(1, 6);
          for (int j = 0; j < nsig; j++) send_signal(random_signal(j == nsig - 1), 1'b0, blank);
          sent += nsig;
        end
      end
    end

    wait_idle();
    if (errors_seen == 0 && frames_due.size() == 0) begin
      $display("tb_can_signal_frame_packer OK");
    end else begin
      $display("tb_can_signal_frame_packer NOT OK");
    end
    $finish;
  end

endmodule
